// ----- hw/rtl/slm_pkg.sv -----
// slm_pkg: shared sizes, codes, types and helpers for the sorted list link merge
// no dependencies; imported by slm_seq and sorted_list_link_merge
package slm_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned OIDX_W = 4;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  localparam logic LIST_A = 1'b0;
  localparam logic LIST_B = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_STEP  = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_FAULT = 5'b10000
  } seq_state_e;

  typedef struct packed {
    logic              link_list;
    logic [OIDX_W-1:0] link_index;
    logic              target_list;
    logic [OIDX_W-1:0] target_index;
    logic              status;
    logic              last;
  } rewrite_t;

  typedef struct packed {
    logic             we_a;
    logic             we_b;
    logic [IDX_W-1:0] waddr_a;
    logic [IDX_W-1:0] waddr_b;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } ram_ctl_t;

  // low VALUE_BITS of the zero-extended input word
  function automatic logic [VALUE_BITS-1:0] store_val(input logic [31:0] v);
    logic [63:0] w;
    w = {32'd0, v};
    return w[VALUE_BITS-1:0];
  endfunction

  // element index cut or padded to the result index width
  function automatic logic [OIDX_W-1:0] out_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W+OIDX_W-1:0] w;
    w = {{OIDX_W{1'b0}}, i};
    return w[OIDX_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/slm_ram.sv -----
// slm_ram: generic single write, single read ram with registered read data
// no dependencies; used for both list stores
module slm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/slm_seq.sv -----
// slm_seq: load counters, merge walk sequencer and the shared signed comparator
// depends on slm_pkg; drives the two list rams and the result register
module slm_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [slm_pkg::VALUE_BITS-1:0] rdata_a_i,
  input  logic [slm_pkg::VALUE_BITS-1:0] rdata_b_i,
  output slm_pkg::ram_ctl_t             ram_o,
  output logic                          emit_valid_o,
  input  logic                          emit_ready_i,
  output slm_pkg::rewrite_t             rewrite_o
);
  import slm_pkg::*;

  seq_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_a_q, count_a_d, count_b_q, count_b_d;
  logic [CNT_W-1:0] walk_a_q, walk_a_d, walk_b_q, walk_b_d;
  logic             prev_list_q, prev_list_d;
  logic [IDX_W-1:0] prev_index_q, prev_index_d;
  logic             prev_valid_q, prev_valid_d;

  logic             accept;
  logic             take_a;
  logic             done;
  logic [IDX_W-1:0] take_idx;
  logic [CNT_W-1:0] walk_inc;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // shared comparator, ties go to list b
  assign take_a   = $signed(rdata_a_i) < $signed(rdata_b_i);
  assign walk_inc = (take_a ? walk_a_q : walk_b_q) + CNT_W'(1);
  assign take_idx = take_a ? walk_a_q[IDX_W-1:0] : walk_b_q[IDX_W-1:0];
  assign done     = take_a ? (walk_inc == count_a_q) : (walk_inc == count_b_q);

  always_comb begin
    ram_o.we_a    = accept && (kind_i == KIND_LOAD_A) && (count_a_q < CNT_W'(DEPTH));
    ram_o.we_b    = accept && (kind_i == KIND_LOAD_B) && (count_b_q < CNT_W'(DEPTH));
    ram_o.waddr_a = count_a_q[IDX_W-1:0];
    ram_o.waddr_b = count_b_q[IDX_W-1:0];
    ram_o.raddr_a = walk_a_q[IDX_W-1:0];
    ram_o.raddr_b = walk_b_q[IDX_W-1:0];
  end

  always_comb begin
    state_d      = state_q;
    count_a_d    = count_a_q;
    count_b_d    = count_b_q;
    walk_a_d     = walk_a_q;
    walk_b_d     = walk_b_q;
    prev_list_d  = prev_list_q;
    prev_index_d = prev_index_q;
    prev_valid_d = prev_valid_q;
    emit_valid_o = 1'b0;
    rewrite_o    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_LOAD_A: if (ram_o.we_a) count_a_d = count_a_q + CNT_W'(1);
            KIND_LOAD_B: if (ram_o.we_b) count_b_d = count_b_q + CNT_W'(1);
            KIND_START: begin
              if ((count_a_q == '0) || (count_b_q == '0)) begin
                state_d = ST_FAULT;
              end else begin
                state_d = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: state_d = ST_STEP;
      ST_STEP: begin
        emit_valid_o           = prev_valid_q;
        rewrite_o.link_list    = prev_list_q;
        rewrite_o.link_index   = out_idx(prev_index_q);
        rewrite_o.target_list  = take_a ? LIST_A : LIST_B;
        rewrite_o.target_index = out_idx(take_idx);
        if (!prev_valid_q || emit_ready_i) begin
          if (take_a) begin
            walk_a_d = walk_inc;
          end else begin
            walk_b_d = walk_inc;
          end
          prev_list_d  = take_a ? LIST_A : LIST_B;
          prev_index_d = take_idx;
          prev_valid_d = 1'b1;
          state_d      = done ? ST_FINAL : ST_FETCH;
        end
      end
      ST_FINAL: begin
        emit_valid_o           = 1'b1;
        rewrite_o.link_list    = prev_list_q;
        rewrite_o.link_index   = out_idx(prev_index_q);
        rewrite_o.target_list  = ~prev_list_q;
        rewrite_o.target_index = (prev_list_q == LIST_A) ? out_idx(walk_b_q[IDX_W-1:0])
                                                         : out_idx(walk_a_q[IDX_W-1:0]);
        rewrite_o.last         = 1'b1;
        if (emit_ready_i) begin
          count_a_d    = '0;
          count_b_d    = '0;
          walk_a_d     = '0;
          walk_b_d     = '0;
          prev_list_d  = LIST_A;
          prev_index_d = '0;
          prev_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      ST_FAULT: begin
        emit_valid_o     = 1'b1;
        rewrite_o.status = 1'b1;
        rewrite_o.last   = 1'b1;
        if (emit_ready_i) begin
          count_a_d = '0;
          count_b_d = '0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_a_q    <= '0;
      count_b_q    <= '0;
      walk_a_q     <= '0;
      walk_b_q     <= '0;
      prev_list_q  <= LIST_A;
      prev_index_q <= '0;
      prev_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_a_q    <= count_a_d;
      count_b_q    <= count_b_d;
      walk_a_q     <= walk_a_d;
      walk_b_q     <= walk_b_d;
      prev_list_q  <= prev_list_d;
      prev_index_q <= prev_index_d;
      prev_valid_q <= prev_valid_d;
    end
  end

  // walks never pass the loaded counts
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk_a_q <= count_a_q) && (walk_b_q <= count_b_q))
    else $error("walk beyond list count");

  // idle means a clean run state
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (walk_a_q == '0) && (walk_b_q == '0) && !prev_valid_q)
    else $error("run state not cleared");

  // a stalled rewrite holds the walk
  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_STEP) && emit_valid_o && !emit_ready_i)
      |=> $stable(walk_a_q) && $stable(walk_b_q) && (state_q == ST_STEP))
    else $error("walk moved under stall");

  // only the final or fault beat carries last
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && rewrite_o.last) |-> (state_q == ST_FINAL) || (state_q == ST_FAULT))
    else $error("last outside end of run");

endmodule

// ----- hw/rtl/sorted_list_link_merge.sv -----
// sorted_list_link_merge: loads two ascending lists and merges them by link rewrites
// a load beat writes its list store directly; a start beat with both lists loaded walks
// ST_FETCH (one ram read) and ST_STEP (one shared compare) per element taken, and each
// ST_STEP after the first emits a rewrite; ST_FINAL emits the last beat, and a start beat
// with an empty list goes to ST_FAULT for the error beat; input stalled for the whole merge run
// reset: rst_ni async active low clears counts, walks and result valid; stores keep data
module sorted_list_link_merge (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic signed [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        link_list_o,
  output logic [3:0]  link_index_o,
  output logic        target_list_o,
  output logic [3:0]  target_index_o,
  output logic        status_o,
  output logic        last_result_o
);
  import slm_pkg::*;

  ram_ctl_t                ram_ctl;
  logic [VALUE_BITS-1:0]   wdata;
  logic [VALUE_BITS-1:0]   rdata_a;
  logic [VALUE_BITS-1:0]   rdata_b;
  logic                    emit_valid;
  logic                    emit_ready;
  rewrite_t                rewrite;

  // result register
  logic                    out_valid_q, out_valid_d;
  rewrite_t                out_q;

  // load beats keep the low value bits
  assign wdata = store_val(value_i);

  // list a store
  slm_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (ram_ctl.we_a),
    .waddr_i(ram_ctl.waddr_a),
    .wdata_i(wdata),
    .raddr_i(ram_ctl.raddr_a),
    .rdata_o(rdata_a)
  );

  // list b store
  slm_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (ram_ctl.we_b),
    .waddr_i(ram_ctl.waddr_b),
    .wdata_i(wdata),
    .raddr_i(ram_ctl.raddr_b),
    .rdata_o(rdata_b)
  );

  // sequencer with the shared comparator
  slm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .ram_o       (ram_ctl),
    .emit_valid_o(emit_valid),
    .emit_ready_i(emit_ready),
    .rewrite_o   (rewrite)
  );

  // slot is free when empty or being drained this cycle
  assign emit_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_valid && emit_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) begin
      out_q <= rewrite;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign link_list_o    = out_q.link_list;
  assign link_index_o   = out_q.link_index;
  assign target_list_o  = out_q.target_list;
  assign target_index_o = out_q.target_index;
  assign status_o       = out_q.status;
  assign last_result_o  = out_q.last;

  // a beat waiting under stall keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

  // no new start while a run is in flight
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid && !rewrite.last) |-> in_stall_o)
    else $error("input taken during merge");

  // an error beat is always the last of its run
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_o) |-> last_result_o)
    else $error("error beat without last");

endmodule
